/* design/mtrsa_pkg.sv */
// ----------------------------------------------------------------------------
// mtrsa_pkg
// Types, codes and helpers for the memory type range slot allocator.
// ----------------------------------------------------------------------------
package mtrsa_pkg;

  localparam int unsigned CountW   = 6;
  localparam int unsigned IdW      = 32;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned MinLenLg = 12;

  localparam logic [AddrW-1:0] MinLen = AddrW'(64'd1 << MinLenLg);
  localparam logic [IdW-1:0]   OwnerNone = '1;

  localparam logic CmdSet   = 1'b0;
  localparam logic CmdUnset = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadValue = 2'd1;
  localparam logic [1:0] StatusNotSupp  = 2'd2;
  localparam logic [1:0] StatusNoSlot   = 2'd3;

  localparam logic [3:0] TypeNone = 4'd0;
  localparam logic [3:0] TypeUc   = 4'd1;
  localparam logic [3:0] TypeWc   = 4'd2;
  localparam logic [3:0] TypeWt   = 4'd3;
  localparam logic [3:0] TypeWp   = 4'd4;
  localparam logic [3:0] TypeWb   = 4'd5;

  localparam logic [2:0] HwUc = 3'd0;
  localparam logic [2:0] HwWc = 3'd1;
  localparam logic [2:0] HwWt = 3'd4;
  localparam logic [2:0] HwWp = 3'd5;
  localparam logic [2:0] HwWb = 3'd6;

  typedef struct packed {
    logic                    command;
    logic signed [IdW-1:0]   area_id;
    logic [AddrW-1:0]        range_base;
    logic [AddrW-1:0]        range_length;
    logic [3:0]              type_code;
    logic                    had_type;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             write_valid;
    logic [SlotW-1:0] write_slot;
    logic [AddrW-1:0] write_base;
    logic [AddrW-1:0] write_length;
    logic [2:0]       write_type;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StCheck,
    StScan,
    StResp
  } state_e;

  function automatic logic [2:0] hw_type(input logic [3:0] tc);
    logic [2:0] hw;
    unique case (tc)
      TypeUc:  hw = HwUc;
      TypeWc:  hw = HwWc;
      TypeWt:  hw = HwWt;
      TypeWp:  hw = HwWp;
      TypeWb:  hw = HwWb;
      default: hw = HwUc;
    endcase
    return hw;
  endfunction

endpackage

/* design/memory_type_range_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// memory_type_range_slot_allocator_core
// Variable range register allocator: claims and frees range slots per owner.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A set request with type none or an
// invalid type, a set on a zero slot count or with an oversized length, and
// an unset request without a type answer in the cycle after acceptance. A set
// request otherwise rounds its length up by one doubling per cycle (one 64-bit
// compare per step), checks for wrap and alignment, and scans the slots one
// per cycle; an unset request with a type goes straight to the scan. The block
// takes no new word until the result word has been taken.
module memory_type_range_slot_allocator_core
  import mtrsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_data_o
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  rsp_t                rsp_q, rsp_d;
  logic [AddrW-1:0]    pow_q, pow_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CountW-1:0]   slot_count_q;
  logic [MAX_SLOTS-1:0] busy_q;
  logic [IdW-1:0]      owner_q [MAX_SLOTS];

  logic [CntW-1:0]     eff_count;
  logic [IdxW-1:0]     idx;
  logic                hit;
  logic                claim;
  logic                release_slot;
  logic [AddrW:0]      end_sum;
  logic                misaligned;
  logic                len_huge;

  assign eff_count = (slot_count_q > CountW'(MAX_SLOTS)) ? CntW'(MAX_SLOTS)
                                                         : CntW'(slot_count_q);
  assign idx       = cnt_q[IdxW-1:0];
  assign hit       = (req_q.command == CmdSet) ? !busy_q[idx]
                   : (owner_q[idx] == $unsigned(req_q.area_id));
  assign end_sum   = {1'b0, req_q.range_base} + {1'b0, pow_q};
  assign misaligned = |(req_q.range_base & (pow_q - AddrW'(1)));
  assign len_huge  = in_data_i.range_length[AddrW-1] &&
                     (|in_data_i.range_length[AddrW-2:0]);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    rsp_d        = rsp_q;
    pow_d        = pow_q;
    cnt_d        = cnt_q;
    claim        = 1'b0;
    release_slot = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          rsp_d   = '0;
          pow_d   = MinLen;
          cnt_d   = '0;
          state_d = StResp;
          if (in_data_i.command == CmdUnset) begin
            if (in_data_i.had_type) begin
              state_d = StScan;
            end
          end else if (in_data_i.type_code == TypeNone) begin
            rsp_d.status = StatusOk;
          end else if (in_data_i.type_code > TypeWb) begin
            rsp_d.status = StatusBadValue;
          end else if (slot_count_q == '0) begin
            rsp_d.status = StatusNotSupp;
          end else if (len_huge) begin
            rsp_d.status = StatusBadValue;
          end else begin
            state_d = StRound;
          end
        end
      end
      StRound: begin
        if (req_q.range_length > pow_q) begin
          pow_d = {pow_q[AddrW-2:0], 1'b0};
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (end_sum[AddrW] || misaligned) begin
          rsp_d.status = StatusBadValue;
          state_d      = StResp;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (cnt_q >= eff_count) begin
          rsp_d.status = (req_q.command == CmdSet) ? StatusNoSlot : StatusOk;
          state_d      = StResp;
        end else if (hit) begin
          rsp_d.status      = StatusOk;
          rsp_d.write_valid = 1'b1;
          rsp_d.write_slot  = SlotW'(idx);
          if (req_q.command == CmdSet) begin
            claim              = 1'b1;
            rsp_d.write_base   = req_q.range_base;
            rsp_d.write_length = pow_q;
            rsp_d.write_type   = hw_type(req_q.type_code);
          end else begin
            release_slot = 1'b1;
          end
          state_d = StResp;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StResp: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      slot_count_q <= CountW'(8);
      busy_q       <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        owner_q[i] <= OwnerNone;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      if (claim) begin
        busy_q[idx]  <= 1'b1;
        owner_q[idx] <= $unsigned(req_q.area_id);
      end else if (release_slot) begin
        busy_q[idx]  <= 1'b0;
        owner_q[idx] <= OwnerNone;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    pow_q <= pow_d;
    cnt_q <= cnt_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StResp);
  assign out_data_o  = rsp_q;

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accepting while a result word is pending");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_valid |-> out_data_o.status == StatusOk)
    else $error("slot write with failing status");

  a_len_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_valid && (out_data_o.write_length != '0)
    |-> $onehot(out_data_o.write_length) && (out_data_o.write_length[11:0] == '0))
    else $error("written length not a power of two of at least 4096");

  a_busy_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q ^ $past(busy_q)) <= 1)
    else $error("more than one slot changed in a cycle");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_valid |-> out_data_o.write_slot < MAX_SLOTS)
    else $error("slot index beyond the slot array");
`endif

endmodule

/* tb/sv/tb_memory_type_range_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_memory_type_range_slot_allocator_core
// Self-checking bench for the range slot allocator. Request words are sent
// with random gaps and result words are taken with random stalls. A local
// copy of the slot table and owner list computes the result word each
// request should produce. Directed checks cover the type, length, wrap and
// alignment rejects, full tables, unset matching and the slot_count extremes.
// Random phases under several slot_count settings follow.
// ----------------------------------------------------------------------------
module tb_memory_type_range_slot_allocator_core;
  import mtrsa_pkg::*;

  localparam int unsigned MaxSlots   = 32;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 100;
  localparam logic [3:0]  TypeBadLow = 4'd6;
  localparam logic [3:0]  TypeBadTop = 4'd15;
  localparam logic [AddrW-1:0] HalfSpace = 64'h8000_0000_0000_0000;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rsp_t              out_data_o;

  logic [CountW-1:0] cur_count  = 6'd8;
  logic [31:0]       busy_slots = '0;
  logic [IdW-1:0]    owner_of [MaxSlots];
  rsp_t              pending_writes [$];

  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  int unsigned errors        = 0;
  int unsigned words_in      = 0;
  int unsigned writes_seen   = 0;
  int unsigned rejects_seen  = 0;
  int unsigned settings_used = 0;
  int unsigned cycles        = 0;

  memory_type_range_slot_allocator_core #(
    .MAX_SLOTS(MaxSlots)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_memory_type_range_slot_allocator_core: errors");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 20) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  function automatic int unsigned idle_len(input logic calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Slot table update and the result word it yields.
  function automatic rsp_t model_slot_write(input req_t r);
    rsp_t        o;
    logic [2:0]  hw;
    logic [63:0] rl;
    int unsigned n;
    int unsigned i;
    logic        done;
    o    = '0;
    hw   = HwUc;
    rl   = MinLen;
    done = 1'b0;
    n    = (cur_count > MaxSlots) ? MaxSlots : cur_count;
    if (r.command == CmdUnset) begin
      for (i = 0; i < n && r.had_type && !done; i++) begin
        if (owner_of[i] == r.area_id) begin
          owner_of[i]     = OwnerNone;
          busy_slots[i]   = 1'b0;
          o.write_valid   = 1'b1;
          o.write_slot    = SlotW'(i);
          done            = 1'b1;
        end
      end
      return o;
    end
    case (r.type_code)
      TypeNone: done = 1'b1;
      TypeUc:   hw = HwUc;
      TypeWc:   hw = HwWc;
      TypeWt:   hw = HwWt;
      TypeWp:   hw = HwWp;
      TypeWb:   hw = HwWb;
      default: begin
        o.status = StatusBadValue;
        done     = 1'b1;
      end
    endcase
    if (!done && cur_count == 0) begin
      o.status = StatusNotSupp;
      done     = 1'b1;
    end
    if (!done && r.range_length > HalfSpace) begin
      o.status = StatusBadValue;
      done     = 1'b1;
    end
    if (!done) begin
      while (r.range_length > rl) rl = rl << 1;
      if (r.range_base + rl <= r.range_base || (r.range_base & (rl - 1)) != 0) begin
        o.status = StatusBadValue;
        done     = 1'b1;
      end
    end
    if (!done) begin
      o.status = StatusNoSlot;
      for (i = 0; i < n && !done; i++) begin
        if (!busy_slots[i]) begin
          busy_slots[i]  = 1'b1;
          owner_of[i]    = r.area_id;
          o.status       = StatusOk;
          o.write_valid  = 1'b1;
          o.write_slot   = SlotW'(i);
          o.write_base   = r.range_base;
          o.write_length = rl;
          o.write_type   = hw;
          done           = 1'b1;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        flag_error("result word with nothing pending");
      end else begin
        want = pending_writes.pop_front();
        check_field("status", 64'(out_data_o.status), 64'(want.status));
        check_field("write_valid", 64'(out_data_o.write_valid), 64'(want.write_valid));
        check_field("write_slot", 64'(out_data_o.write_slot), 64'(want.write_slot));
        check_field("write_base", out_data_o.write_base, want.write_base);
        check_field("write_length", out_data_o.write_length, want.write_length);
        check_field("write_type", 64'(out_data_o.write_type), 64'(want.write_type));
      end
      if (out_data_o.write_valid) writes_seen++;
      if (out_data_o.status != StatusOk) rejects_seen++;
    end
  end

  initial begin : rx_stall
    int unsigned n;
    wait (rst_ni);
    forever begin
      n = idle_len(rx_calm);
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = idle_len(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_writes.push_back(model_slot_write(r));
    words_in++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_slot_count(input logic [CountW-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_count = v;
    settings_used++;
  endtask

  function automatic logic [IdW-1:0] rand_id();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return IdW'($urandom_range(0, 15));
    if (roll < 75) return OwnerNone;
    if (roll < 80) return 32'h7FFF_FFFF;
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  function automatic req_t mk_set(input logic [IdW-1:0] id, input logic [63:0] base,
                                  input logic [63:0] len, input logic [3:0] tc);
    req_t r;
    r.command      = CmdSet;
    r.area_id      = id;
    r.range_base   = base;
    r.range_length = len;
    r.type_code    = tc;
    r.had_type     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t mk_unset(input logic [IdW-1:0] id, input logic had);
    req_t r;
    r.command      = CmdUnset;
    r.area_id      = id;
    r.range_base   = rand64();
    r.range_length = rand64();
    r.type_code    = 4'($urandom_range(0, 15));
    r.had_type     = had;
    return r;
  endfunction

  function automatic req_t rand_set();
    int unsigned lg;
    int unsigned roll;
    logic [63:0] rl;
    logic [63:0] len;
    logic [3:0]  tc;
    lg   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 63) : $urandom_range(12, 24);
    rl   = 64'd1 << lg;
    len  = (lg == 12) ? 64'($urandom_range(0, 4096)) : rl - (rand64() % (rl >> 1));
    roll = $urandom_range(0, 99);
    if (roll < 85)      tc = 4'($urandom_range(TypeUc, TypeWb));
    else if (roll < 93) tc = TypeNone;
    else                tc = 4'($urandom_range(TypeBadLow, TypeBadTop));
    return mk_set(rand_id(), rand64() & ~(rl - 1), len, tc);
  endfunction

  function automatic req_t rand_unset();
    logic [IdW-1:0] id;
    id = $urandom_range(0, 1) ? owner_of[$urandom_range(0, MaxSlots - 1)] : rand_id();
    return mk_unset(id, $urandom_range(0, 99) < 85);
  endfunction

  function automatic req_t rand_noise();
    req_t r;
    r = mk_set(rand_id(), rand64(), rand64(), 4'($urandom_range(0, 15)));
    r.command = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic test_type_and_range_checks();
    int unsigned k;
    send_req(mk_set(32'd1, 64'h0, 64'h0, TypeNone));
    send_req(mk_set(32'd1, 64'h0, 64'h0, TypeBadLow));
    send_req(mk_set(32'd1, 64'h0, 64'h0, TypeBadTop));
    send_req(mk_set(32'd10, 64'h0, 64'h0, TypeUc));
    send_req(mk_set(32'd11, 64'h1000, 64'd4096, TypeWc));
    send_req(mk_set(32'd12, 64'h2000, 64'd4097, TypeWt));
    send_req(mk_set(32'h7FFF_FFFF, 64'h0, HalfSpace, TypeWp));
    send_req(mk_set(OwnerNone, HalfSpace, HalfSpace, TypeWb));
    send_req(mk_set(32'd13, 64'h0, HalfSpace + 1, TypeWb));
    send_req(mk_set(32'd13, 64'h0, '1, TypeUc));
    send_req(mk_set(32'd13, 64'hFFFF_FFFF_FFFF_F000, 64'h0, TypeUc));
    send_req(mk_set(32'd13, 64'h800, 64'd4096, TypeUc));
    send_req(mk_set(32'd13, '1, 64'h0, TypeWb));
    send_req(mk_set(32'd14, 64'hFFFF_FFFF_FFFF_E000, 64'd4096, TypeWb));
    for (k = 0; k < 3; k++) send_req(mk_set(15 + k, 64'(k + 1) << 16, 64'd1, TypeWc));
    send_req(mk_set(32'd18, 64'h10_0000, 64'd4096, TypeUc));
    send_req(mk_unset(32'd12, 1'b0));
    send_req(mk_unset(32'd999, 1'b1));
    send_req(mk_unset(32'd12, 1'b1));
    send_req(mk_unset(OwnerNone, 1'b1));
    send_req(mk_set(OwnerNone, 64'h3000, 64'd4096, TypeWt));
    send_req(mk_unset(OwnerNone, 1'b1));
    send_req(mk_unset(32'h7FFF_FFFF, 1'b1));
  endtask

  task automatic test_slot_count_settings();
    int unsigned k;
    set_slot_count(6'd0);
    send_req(mk_set(32'd20, 64'h0, 64'h0, TypeUc));
    send_req(mk_set(32'd20, 64'h0, 64'h0, TypeBadLow + 4'd1));
    send_req(mk_set(32'd20, 64'h0, 64'h0, TypeNone));
    send_req(mk_unset(32'd10, 1'b1));
    set_slot_count(6'd63);
    for (k = 0; k < 27; k++) send_req(mk_set(100 + k, 64'(k) << 20, 64'd4096, TypeWb));
    set_slot_count(6'd3);
    send_req(mk_set(32'd21, 64'h0, 64'h0, TypeUc));
    send_req(mk_unset(32'd120, 1'b1));
    send_req(mk_unset(32'd10, 1'b1));
    send_req(mk_set(32'd200, 64'h4000, 64'd4096, TypeWp));
    set_slot_count(6'd32);
    send_req(mk_unset(32'd120, 1'b1));
    send_req(mk_set(32'd201, 64'h8000, 64'd8192, TypeWc));
    set_slot_count(6'd1);
    send_req(mk_set(32'd202, 64'h0, 64'h0, TypeUc));
    send_req(mk_unset(32'd200, 1'b1));
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned set_pct,
                           input int unsigned calm_items);
    int unsigned k;
    int unsigned roll;
    req_t        r;
    for (k = 0; k < items; k++) begin
      tx_calm = (k < calm_items);
      rx_calm = (k < calm_items);
      if (k == items / 2) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < set_pct)  r = rand_set();
      else if (roll < 85)  r = rand_unset();
      else                 r = rand_noise();
      send_req(r);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    set_slot_count(6'd8);
    run_phase(200, 55, 0);
    set_slot_count(6'd1);
    run_phase(80, 45, 0);
    set_slot_count(6'd32);
    run_phase(200, 60, 50);
    set_slot_count(6'd63);
    run_phase(100, 55, 0);
    set_slot_count(6'd0);
    run_phase(40, 55, 0);
    set_slot_count(6'd5);
    run_phase(180, 50, 0);
  endtask

  initial begin
    foreach (owner_of[j]) owner_of[j] = OwnerNone;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_type_and_range_checks();
    test_slot_count_settings();
    test_random_traffic();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_writes.size() != 0)
      flag_error($sformatf("%0d result words never arrived", pending_writes.size()));
    $display("covered %0d request words under %0d slot_count settings",
             words_in, settings_used + 1);
    $display("slot writes %0d, rejected or full %0d", writes_seen, rejects_seen);
    if (errors == 0) begin
      $display("tb_memory_type_range_slot_allocator_core: clean");
    end else begin
      $display("tb_memory_type_range_slot_allocator_core: errors");
    end
    $finish;
  end

endmodule
